>>> rtl/dual_wheel_incremental_pi_unit_macros.svh
// Assertion helpers for the dual wheel PI unit.
// Both macros sample on clk and are disabled while rst_n is low.
`ifndef DUAL_WHEEL_INCREMENTAL_PI_UNIT_MACROS_SVH
`define DUAL_WHEEL_INCREMENTAL_PI_UNIT_MACROS_SVH

// A condition that must hold at every clock edge.
`define DWPI_ASSERT_ALWAYS(label, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);

// A consequence that must hold in the cycle after its antecedent.
`define DWPI_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/dwpi_pkg.sv
package dwpi_pkg;

    // Drive and duty formats, in 1/256 percent.
    localparam int DRIVE_W         = 16;
    localparam int DUTY_W          = 15;
    localparam int GAIN_W          = 16;
    localparam int DRIVE_FRAC_BITS = 8;
    localparam int FULL_SCALE      = 25600;

    // Register reset values.
    localparam logic [GAIN_W-1:0] PROP_GAIN_RST  = 16'd256;
    localparam logic [GAIN_W-1:0] INT_GAIN_RST   = 16'd102;
    localparam logic [DUTY_W-1:0] DUTY_LIMIT_RST = 15'd12800;

    // Configuration register index, taken from paddr[3:2].
    typedef enum logic [1:0] {
        REG_PROP_GAIN  = 2'd0,
        REG_INT_GAIN   = 2'd1,
        REG_DUTY_LIMIT = 2'd2
    } reg_index_t;

endpackage

>>> rtl/dwpi_in_if.sv
interface dwpi_in_if #(
    parameter int COUNT_BITS = 16
);
    logic                         valid;
    logic                         ready;
    logic signed [COUNT_BITS-1:0] left_count;
    logic signed [COUNT_BITS-1:0] right_count_raw;
    logic signed [COUNT_BITS-1:0] left_target;
    logic signed [COUNT_BITS-1:0] right_target;
    logic                         stop_request;
    logic                         run_enable;

    modport source (
        output valid, left_count, right_count_raw, left_target, right_target,
               stop_request, run_enable,
        input  ready
    );

    modport sink (
        input  valid, left_count, right_count_raw, left_target, right_target,
               stop_request, run_enable,
        output ready
    );
endinterface

>>> rtl/dwpi_out_if.sv
interface dwpi_out_if;
    import dwpi_pkg::*;

    logic                      valid;
    logic                      ready;
    logic [DUTY_W-1:0]         right_fwd_duty;
    logic [DUTY_W-1:0]         right_rev_duty;
    logic [DUTY_W-1:0]         left_fwd_duty;
    logic [DUTY_W-1:0]         left_rev_duty;
    logic signed [DRIVE_W-1:0] left_drive_out;
    logic signed [DRIVE_W-1:0] right_drive_out;

    modport source (
        output valid, right_fwd_duty, right_rev_duty, left_fwd_duty, left_rev_duty,
               left_drive_out, right_drive_out,
        input  ready
    );

    modport sink (
        input  valid, right_fwd_duty, right_rev_duty, left_fwd_duty, left_rev_duty,
               left_drive_out, right_drive_out,
        output ready
    );
endinterface

>>> rtl/dual_wheel_incremental_pi_unit.sv
// Channel   Direction  Content
// sample    in         encoder counts, targets, stop request, run enable per tick
// result    out        four wheel duties and both clamped drives
// apb       in/out     prop_gain (0x0), int_gain (0x4), duty_limit (0x8)
//
// Each request is held in the input register; the compute logic then loads
// the result register, from which the result is presented and can leave
// when result.ready is high. One request is accepted every cycle while the
// result is not stalled; the compute stage updates the drive and error state,
// when running, as it loads the result register, so back-to-back ticks see
// each other's state. A stalled result holds the compute stage, and the input
// register takes a new request when it is empty or the compute stage can move.
// Reset clears the drives, the last errors and the valid flags, and loads
// the register defaults.
module dual_wheel_incremental_pi_unit #(
    parameter int COUNT_BITS     = 16,
    parameter int GAIN_FRAC_BITS = 8
) (
    input  logic        clk,
    input  logic        rst_n,
    dwpi_in_if.sink     sample,
    dwpi_out_if.source  result,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import dwpi_pkg::*;

    `include "dual_wheel_incremental_pi_unit_macros.svh"

    localparam int ERR_W    = COUNT_BITS + 1;
    localparam int DERR_W   = COUNT_BITS + 2;
    localparam int PROD_W   = DERR_W + GAIN_W + 1;
    localparam int INC_W    = PROD_W + 1;
    localparam int UP_SHIFT = (GAIN_FRAC_BITS < DRIVE_FRAC_BITS) ?
                              (DRIVE_FRAC_BITS - GAIN_FRAC_BITS) : 0;
    localparam int DN_SHIFT = (GAIN_FRAC_BITS >= DRIVE_FRAC_BITS) ?
                              (GAIN_FRAC_BITS - DRIVE_FRAC_BITS) : 0;
    localparam int SCL_W    = INC_W + UP_SHIFT;
    localparam int SUM_W    = SCL_W + 1;

    // Configuration registers.
    logic [GAIN_W-1:0] prop_gain_reg;
    logic [GAIN_W-1:0] int_gain_reg;
    logic [DUTY_W-1:0] duty_limit_reg;
    logic [1:0]        reg_idx;
    logic              cfg_write;

    assign pready    = 1'b1;
    assign reg_idx   = paddr[3:2];
    assign cfg_write = psel & penable & pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prop_gain_reg  <= PROP_GAIN_RST;
            int_gain_reg   <= INT_GAIN_RST;
            duty_limit_reg <= DUTY_LIMIT_RST;
        end
        else if (cfg_write)
        begin
            case (reg_idx)
                REG_PROP_GAIN:  prop_gain_reg  <= pwdata[GAIN_W-1:0];
                REG_INT_GAIN:   int_gain_reg   <= pwdata[GAIN_W-1:0];
                REG_DUTY_LIMIT: duty_limit_reg <= pwdata[DUTY_W-1:0];
                default:        ;
            endcase
        end
    end

    // Register read-back.
    always_comb
    begin
        case (reg_idx)
            REG_PROP_GAIN:  prdata = {{(32-GAIN_W){1'b0}}, prop_gain_reg};
            REG_INT_GAIN:   prdata = {{(32-GAIN_W){1'b0}}, int_gain_reg};
            REG_DUTY_LIMIT: prdata = {{(32-DUTY_W){1'b0}}, duty_limit_reg};
            default:        prdata = 32'd0;
        endcase
    end

    // Handshake: the compute stage moves when the result register is free or its result is taken.
    logic s1_valid_reg;
    logic out_valid_reg;
    logic out_load;
    logic s1_load;

    assign out_load     = s1_valid_reg & (~out_valid_reg | result.ready);
    assign sample.ready = ~s1_valid_reg | out_load;
    assign s1_load      = sample.valid & sample.ready;

    // Input register.
    logic signed [COUNT_BITS-1:0] s1_left_count_reg;
    logic signed [COUNT_BITS-1:0] s1_right_count_reg;
    logic signed [COUNT_BITS-1:0] s1_left_target_reg;
    logic signed [COUNT_BITS-1:0] s1_right_target_reg;
    logic                         s1_stop_reg;
    logic                         s1_run_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (sample.ready)
        begin
            s1_valid_reg <= sample.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_load)
        begin
            s1_left_count_reg   <= sample.left_count;
            s1_right_count_reg  <= sample.right_count_raw;
            s1_left_target_reg  <= sample.left_target;
            s1_right_target_reg <= sample.right_target;
            s1_stop_reg         <= sample.stop_request;
            s1_run_reg          <= sample.run_enable;
        end
    end

    // Per-wheel state; index 0 is the left wheel, 1 the right wheel.
    logic signed [DRIVE_W-1:0] drive_reg    [2];
    logic signed [ERR_W-1:0]   last_err_reg [2];

    logic signed [ERR_W-1:0]   err       [2];
    logic signed [DERR_W-1:0]  derr      [2];
    logic signed [PROD_W-1:0]  prod_p    [2];
    logic signed [PROD_W-1:0]  prod_i    [2];
    logic signed [INC_W-1:0]   inc       [2];
    logic signed [SCL_W-1:0]   scaled    [2];
    logic signed [SUM_W-1:0]   sum       [2];
    logic signed [DRIVE_W-1:0] drive_new [2];
    logic [DUTY_W-1:0]         lim;
    logic signed [SUM_W-1:0]   lim_pos;
    logic signed [SUM_W-1:0]   lim_neg;
    logic signed [ERR_W-1:0]   tgt_l;
    logic signed [ERR_W-1:0]   tgt_r;

    // Error terms; the right count is negated by adding it to the target.
    always_comb
    begin
        tgt_l  = s1_stop_reg ? '0 : ERR_W'(s1_left_target_reg);
        tgt_r  = s1_stop_reg ? '0 : ERR_W'(s1_right_target_reg);
        err[0] = tgt_l - ERR_W'(s1_left_count_reg);
        err[1] = tgt_r + ERR_W'(s1_right_count_reg);
    end

    // Clamp level, saturated at full scale.
    always_comb
    begin
        lim     = (duty_limit_reg > DUTY_W'(FULL_SCALE)) ? DUTY_W'(FULL_SCALE)
                                                         : duty_limit_reg;
        lim_pos = $signed({{(SUM_W-DUTY_W){1'b0}}, lim});
        lim_neg = -lim_pos;
    end

    // Incremental PI update and clamp, one lane per wheel.
    always_comb
    begin
        for (int i = 0; i < 2; i++)
        begin
            derr[i]   = DERR_W'(err[i]) - DERR_W'(last_err_reg[i]);
            prod_p[i] = $signed({1'b0, prop_gain_reg}) * derr[i];
            prod_i[i] = $signed({1'b0, int_gain_reg}) * err[i];
            inc[i]    = INC_W'(prod_p[i]) + INC_W'(prod_i[i]);
            scaled[i] = (SCL_W'(inc[i]) <<< UP_SHIFT) >>> DN_SHIFT;
            sum[i]    = SUM_W'(drive_reg[i]) + SUM_W'(scaled[i]);
            if (sum[i] > lim_pos)
            begin
                drive_new[i] = DRIVE_W'(lim_pos);
            end
            else if (sum[i] < lim_neg)
            begin
                drive_new[i] = DRIVE_W'(lim_neg);
            end
            else
            begin
                drive_new[i] = DRIVE_W'(sum[i]);
            end
        end
    end

    // State update as the tick leaves the compute stage; held while not running.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 2; i++)
            begin
                drive_reg[i]    <= '0;
                last_err_reg[i] <= '0;
            end
        end
        else if (out_load && s1_run_reg)
        begin
            for (int i = 0; i < 2; i++)
            begin
                drive_reg[i]    <= drive_new[i];
                last_err_reg[i] <= err[i];
            end
        end
    end

    // Result register.
    logic [DUTY_W-1:0]         right_fwd_next;
    logic [DUTY_W-1:0]         right_rev_next;
    logic [DUTY_W-1:0]         left_fwd_next;
    logic [DUTY_W-1:0]         left_rev_next;
    logic signed [DRIVE_W-1:0] left_drive_next;
    logic signed [DRIVE_W-1:0] right_drive_next;

    logic [DUTY_W-1:0]         right_fwd_reg;
    logic [DUTY_W-1:0]         right_rev_reg;
    logic [DUTY_W-1:0]         left_fwd_reg;
    logic [DUTY_W-1:0]         left_rev_reg;
    logic signed [DRIVE_W-1:0] left_drive_out_reg;
    logic signed [DRIVE_W-1:0] right_drive_out_reg;

    // Split each new drive into forward and reverse duties; all duties are zero while not running.
    always_comb
    begin
        right_fwd_next   = '0;
        right_rev_next   = '0;
        left_fwd_next    = '0;
        left_rev_next    = '0;
        left_drive_next  = drive_reg[0];
        right_drive_next = drive_reg[1];
        if (s1_run_reg)
        begin
            left_drive_next  = drive_new[0];
            right_drive_next = drive_new[1];
            if (drive_new[1] > 0)
            begin
                right_fwd_next = DUTY_W'(drive_new[1]);
            end
            else
            begin
                right_rev_next = DUTY_W'(-drive_new[1]);
            end
            if (drive_new[0] > 0)
            begin
                left_fwd_next = DUTY_W'(drive_new[0]);
            end
            else
            begin
                left_rev_next = DUTY_W'(-drive_new[0]);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (~out_valid_reg | result.ready)
        begin
            out_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            right_fwd_reg       <= right_fwd_next;
            right_rev_reg       <= right_rev_next;
            left_fwd_reg        <= left_fwd_next;
            left_rev_reg        <= left_rev_next;
            left_drive_out_reg  <= left_drive_next;
            right_drive_out_reg <= right_drive_next;
        end
    end

    assign result.valid           = out_valid_reg;
    assign result.right_fwd_duty  = right_fwd_reg;
    assign result.right_rev_duty  = right_rev_reg;
    assign result.left_fwd_duty   = left_fwd_reg;
    assign result.left_rev_duty   = left_rev_reg;
    assign result.left_drive_out  = left_drive_out_reg;
    assign result.right_drive_out = right_drive_out_reg;

    // Checks on the drive state and the result register.
    `DWPI_ASSERT_ALWAYS(a_drive_in_range,
        (drive_reg[0] <= DRIVE_W'(FULL_SCALE)) && (drive_reg[0] >= -DRIVE_W'(FULL_SCALE)) &&
        (drive_reg[1] <= DRIVE_W'(FULL_SCALE)) && (drive_reg[1] >= -DRIVE_W'(FULL_SCALE)),
        "drive state outside full scale")
    `DWPI_ASSERT_NEXT(a_out_matches_state, out_load,
        (left_drive_out_reg == drive_reg[0]) && (right_drive_out_reg == drive_reg[1]),
        "result drive differs from drive state")
    `DWPI_ASSERT_NEXT(a_hold_when_stopped, out_load && !s1_run_reg,
        $stable(drive_reg[0]) && $stable(drive_reg[1]) &&
        $stable(last_err_reg[0]) && $stable(last_err_reg[1]) &&
        (left_fwd_reg == '0) && (left_rev_reg == '0),
        "state changed or duty nonzero with run disabled")

endmodule
